@@ sv/lcpts_pkg.sv @@
package lcpts_pkg;

  localparam int NUM_TARGETS = 4;
  localparam int TGT_W       = 7;
  localparam int SIZE_W      = 7;
  localparam int LAT_IN_W    = 16;
  localparam int PAGE_W      = 14;
  localparam int FIT_OUT_W   = 7;
  localparam int LAT_W       = 22;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 7;

  // Internal accumulator widths cover the whole legal parameter range
  // (up to 256 lines of at most 127 bytes).
  localparam int EXC_W = 15;
  localparam int FIT_W = 9;
  localparam int SUM_W = 18;

  localparam logic [SUM_W-1:0]     META_BYTES = SUM_W'(64);
  localparam logic [PAGE_W-1:0]    PAGE_MAX   = {PAGE_W{1'b1}};
  localparam logic [FIT_OUT_W-1:0] FIT_MAX    = {FIT_OUT_W{1'b1}};
  localparam logic [LAT_W-1:0]     LAT_MAX    = {LAT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_0  = 3'd0,
    CFG_TARGET_1  = 3'd1,
    CFG_TARGET_2  = 3'd2,
    CFG_TARGET_3  = 3'd3,
    CFG_LAT_EN    = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [NUM_TARGETS-1:0][TGT_W-1:0] target;
    logic                              lat_en;
  } cfg_t;

  // One classified line on its way from the front to the back.
  typedef struct packed {
    logic [SIZE_W-1:0]      size;
    logic [NUM_TARGETS-1:0] exceed;
    logic [LAT_IN_W-1:0]    latency;
    logic                   last;
  } line_word_t;

  typedef struct packed {
    logic [PAGE_W-1:0]    page_bytes;
    logic [FIT_OUT_W-1:0] lines_in_region;
    logic [LAT_W-1:0]     total_latency;
    logic                 page_too_big;
  } result_t;

endpackage

@@ sv/lcpts_fifo.sv @@
module lcpts_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

@@ sv/lcpts_front.sv @@
module lcpts_front #(
  parameter int LINES_PER_PAGE = 64,
  parameter int LINE_BYTES     = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lcpts_pkg::cfg_t                     cfg,
  input  logic                                in_valid,
  input  logic [lcpts_pkg::SIZE_W-1:0]        line_size,
  input  logic [lcpts_pkg::LAT_IN_W-1:0]      line_latency,
  input  logic                                q_full,
  output logic                                q_wr,
  output lcpts_pkg::line_word_t               q_data
);

  localparam int CNT_W = (LINES_PER_PAGE > 1) ? $clog2(LINES_PER_PAGE) : 1;
  localparam logic [8:0] LINE_MAX = 9'(LINE_BYTES);

  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         last;
  logic [lcpts_pkg::SIZE_W-1:0] size_c;

  assign q_wr = in_valid && !q_full;
  assign last = (cnt_r == CNT_W'(LINES_PER_PAGE - 1));

  // A line never compresses to more than its raw size.
  always_comb begin
    size_c = line_size;
    if ({2'b00, line_size} > LINE_MAX) begin
      size_c = LINE_MAX[lcpts_pkg::SIZE_W-1:0];
    end
  end

  always_comb begin
    q_data.size    = size_c;
    q_data.latency = line_latency;
    q_data.last    = last;
    for (int i = 0; i < lcpts_pkg::NUM_TARGETS; i++) begin
      q_data.exceed[i] = (size_c > cfg.target[i]);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_wr) begin
      cnt_nxt = last ? '0 : cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ sv/lcpts_back.sv @@
module lcpts_back #(
  parameter int LINES_PER_PAGE = 64,
  parameter int PAGE_BYTES     = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lcpts_pkg::cfg_t       cfg,
  input  logic                  q_empty,
  input  lcpts_pkg::line_word_t q_data,
  output logic                  q_rd,
  input  logic                  res_full,
  output logic                  res_wr,
  output lcpts_pkg::result_t    res_data
);

  localparam int NT = lcpts_pkg::NUM_TARGETS;
  localparam int EW = lcpts_pkg::EXC_W;
  localparam int FW = lcpts_pkg::FIT_W;
  localparam int SW = lcpts_pkg::SUM_W;
  localparam int LW = lcpts_pkg::LAT_W;

  // Running page accumulators.
  logic [NT-1:0][EW-1:0] exc_r, exc_nxt, exc_upd;
  logic [NT-1:0][FW-1:0] fit_r, fit_nxt, fit_upd;
  logic [LW-1:0]         lat_r, lat_nxt, lat_upd;
  logic [LW:0]           lat_wide;

  // Finished page totals waiting for the selection stage.
  logic                  fin_v_r, fin_v_nxt;
  logic [NT-1:0][EW-1:0] fin_exc_r;
  logic [NT-1:0][FW-1:0] fin_fit_r;
  logic [LW-1:0]         fin_lat_r;

  assign res_wr = fin_v_r && !res_full;
  assign q_rd   = !q_empty && (!fin_v_r || !res_full);

  always_comb begin
    for (int i = 0; i < NT; i++) begin
      exc_upd[i] = exc_r[i] + (q_data.exceed[i] ? EW'(q_data.size) : '0);
      fit_upd[i] = fit_r[i] + (q_data.exceed[i] ? '0 : FW'(1));
    end
    lat_wide = {1'b0, lat_r} + (LW + 1)'(q_data.latency);
    lat_upd  = lat_wide[LW] ? lcpts_pkg::LAT_MAX : lat_wide[LW-1:0];
  end

  always_comb begin
    exc_nxt   = exc_r;
    fit_nxt   = fit_r;
    lat_nxt   = lat_r;
    fin_v_nxt = fin_v_r && res_full;
    if (q_rd) begin
      if (q_data.last) begin
        exc_nxt   = '0;
        fit_nxt   = '0;
        lat_nxt   = '0;
        fin_v_nxt = 1'b1;
      end else begin
        exc_nxt = exc_upd;
        fit_nxt = fit_upd;
        lat_nxt = lat_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exc_r   <= '0;
      fit_r   <= '0;
      lat_r   <= '0;
      fin_v_r <= 1'b0;
    end else begin
      exc_r   <= exc_nxt;
      fit_r   <= fit_nxt;
      lat_r   <= lat_nxt;
      fin_v_r <= fin_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd && q_data.last) begin
      fin_exc_r <= exc_upd;
      fin_fit_r <= fit_upd;
      fin_lat_r <= lat_upd;
    end
  end

  // Page size per target and the pick of the smallest. On a tie the later
  // target wins only with fewer fitting lines.
  logic [NT-1:0][SW-1:0] size;
  logic [SW-1:0]         best_size;
  logic [FW-1:0]         best_fit;
  logic [lcpts_pkg::PAGE_W-1:0] page_sat;

  always_comb begin
    for (int i = 0; i < NT; i++) begin
      size[i] = SW'(cfg.target[i]) * SW'(LINES_PER_PAGE)
              + lcpts_pkg::META_BYTES + SW'(fin_exc_r[i]);
    end
    best_size = size[0];
    best_fit  = fin_fit_r[0];
    for (int i = 1; i < NT; i++) begin
      if ((size[i] < best_size) ||
          ((size[i] == best_size) && (fin_fit_r[i] < best_fit))) begin
        best_size = size[i];
        best_fit  = fin_fit_r[i];
      end
    end
    page_sat = (best_size > SW'(lcpts_pkg::PAGE_MAX)) ? lcpts_pkg::PAGE_MAX
             : best_size[lcpts_pkg::PAGE_W-1:0];
    res_data.page_bytes      = page_sat;
    res_data.lines_in_region = (best_fit > FW'(lcpts_pkg::FIT_MAX)) ? lcpts_pkg::FIT_MAX
                             : best_fit[lcpts_pkg::FIT_OUT_W-1:0];
    res_data.total_latency   = cfg.lat_en ? fin_lat_r : '0;
    res_data.page_too_big    = (SW'(page_sat) > SW'(PAGE_BYTES));
  end

endmodule

@@ sv/lcp_page_target_select_core.sv @@
// Channel  | Ports                                        | Moves one word when
// ---------+----------------------------------------------+---------------------------
// input    | in_push, in_full, in_line_size, in_line_lat. | in_push && !in_full
// result   | out_empty, out_pop, out_page_bytes, ...      | out_pop && !out_empty
// config   | cfg_we, cfg_index, cfg_wdata                 | cfg_we
//
// One line word is taken every cycle as long as the line queue between the
// front and the back has room. A page result becomes visible on the result
// ports once its last line word has passed through the line queue and the
// finished-page registers, whose selection logic writes the result queue.
// Synchronous reset clears all counters, accumulators and queues at once and
// loads the default target sizes. A full result queue stalls the back, which
// then lets the line queue fill and raises in_full; the front never waits on
// anything else.
module lcp_page_target_select_core #(
  parameter int LINES_PER_PAGE = 64,
  parameter int LINE_BYTES     = 64,
  parameter int PAGE_BYTES     = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [lcpts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lcpts_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic [lcpts_pkg::SIZE_W-1:0]         in_line_size,
  input  logic [lcpts_pkg::LAT_IN_W-1:0]       in_line_latency,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic [lcpts_pkg::PAGE_W-1:0]         out_page_bytes,
  output logic [lcpts_pkg::FIT_OUT_W-1:0]      out_lines_in_region,
  output logic [lcpts_pkg::LAT_W-1:0]          out_total_latency,
  output logic                                 out_page_too_big
);

  // Configuration registers. Writes to unused indexes are dropped.
  lcpts_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (lcpts_pkg::cfg_index_t'(cfg_index))
        lcpts_pkg::CFG_TARGET_0: cfg_nxt.target[0] = cfg_wdata;
        lcpts_pkg::CFG_TARGET_1: cfg_nxt.target[1] = cfg_wdata;
        lcpts_pkg::CFG_TARGET_2: cfg_nxt.target[2] = cfg_wdata;
        lcpts_pkg::CFG_TARGET_3: cfg_nxt.target[3] = cfg_wdata;
        lcpts_pkg::CFG_LAT_EN:   cfg_nxt.lat_en    = cfg_wdata[0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target[0] <= 7'd0;
      cfg_r.target[1] <= 7'd8;
      cfg_r.target[2] <= 7'd16;
      cfg_r.target[3] <= 7'd32;
      cfg_r.lat_en    <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front classifies each line against all four targets and tags the
  // last line of a page.
  logic                  lq_wr, lq_full, lq_rd, lq_empty;
  lcpts_pkg::line_word_t lq_wdata, lq_rdata;

  assign in_full = lq_full;

  lcpts_front #(
    .LINES_PER_PAGE (LINES_PER_PAGE),
    .LINE_BYTES     (LINE_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_push),
    .line_size    (in_line_size),
    .line_latency (in_line_latency),
    .q_full       (lq_full),
    .q_wr         (lq_wr),
    .q_data       (lq_wdata)
  );

  lcpts_fifo #(
    .W     ($bits(lcpts_pkg::line_word_t)),
    .DEPTH (2)
  ) u_line_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (lq_wr),
    .wr_data (lq_wdata),
    .full    (lq_full),
    .rd_en   (lq_rd),
    .rd_data (lq_rdata),
    .empty   (lq_empty)
  );

  // The back accumulates exception bytes, fit counts and latency, and
  // after the last line picks the target with the smallest page.
  logic               rq_wr, rq_full;
  lcpts_pkg::result_t rq_wdata, rq_rdata;

  lcpts_back #(
    .LINES_PER_PAGE (LINES_PER_PAGE),
    .PAGE_BYTES     (PAGE_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (lq_empty),
    .q_data   (lq_rdata),
    .q_rd     (lq_rd),
    .res_full (rq_full),
    .res_wr   (rq_wr),
    .res_data (rq_wdata)
  );

  lcpts_fifo #(
    .W     ($bits(lcpts_pkg::result_t)),
    .DEPTH (2)
  ) u_result_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (rq_wr),
    .wr_data (rq_wdata),
    .full    (rq_full),
    .rd_en   (out_pop),
    .rd_data (rq_rdata),
    .empty   (out_empty)
  );

  assign out_page_bytes      = rq_rdata.page_bytes;
  assign out_lines_in_region = rq_rdata.lines_in_region;
  assign out_total_latency   = rq_rdata.total_latency;
  assign out_page_too_big    = rq_rdata.page_too_big;

  // The selection stage only writes when the result queue has room.
  a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    rq_wr |-> !rq_full)
    else $error("result written into a full result queue");

  // The too-big flag must agree with the reported page size.
  a_too_big_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_page_too_big == (32'(out_page_bytes) > 32'(PAGE_BYTES))))
    else $error("page_too_big disagrees with page_bytes");

  // No target can hold more lines than a page has.
  a_fit_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (32'(out_lines_in_region) <= 32'(LINES_PER_PAGE)))
    else $error("lines_in_region exceeds lines per page");

  // Right after reset no result is pending.
  a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> out_empty)
    else $error("result pending right after reset");

endmodule

@@ tb/sv/lcp_page_target_select_core_tb.sv @@
`timescale 1ns / 100ps

module lcp_page_target_select_core_tb;

  localparam int LINES_PER_PAGE = 64;
  localparam int LINE_BYTES     = 64;
  localparam int PAGE_BYTES     = 4096;
  localparam int META_BYTES_TB  = 64;
  localparam int PHASES         = 10;
  // A result trails the last line word through both core queues; this pause
  // covers that with margin before a register write or the end.
  localparam int SETTLE_CYCLES  = 8;

  // One line word as the input channel carries it.
  typedef struct packed {
    logic [lcpts_pkg::SIZE_W-1:0]   size;
    logic [lcpts_pkg::LAT_IN_W-1:0] latency;
  } line_word_tb_t;

  // Shapes of random page content. Each page of 64 line words gets one.
  typedef enum int {
    MIX_UNIFORM,
    MIX_FULL,
    MIX_TIE,
    MIX_SMALL,
    MIX_FLAT
  } page_mix_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                             cfg_we    = 1'b0;
  logic [lcpts_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [lcpts_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  logic                             in_push         = 1'b0;
  logic                             in_full;
  logic [lcpts_pkg::SIZE_W-1:0]     in_line_size    = '0;
  logic [lcpts_pkg::LAT_IN_W-1:0]   in_line_latency = '0;

  logic                             out_empty;
  logic                             out_pop = 1'b0;
  logic [lcpts_pkg::PAGE_W-1:0]     out_page_bytes;
  logic [lcpts_pkg::FIT_OUT_W-1:0]  out_lines_in_region;
  logic [lcpts_pkg::LAT_W-1:0]      out_total_latency;
  logic                             out_page_too_big;

  lcp_page_target_select_core #(
    .LINES_PER_PAGE(LINES_PER_PAGE),
    .LINE_BYTES    (LINE_BYTES),
    .PAGE_BYTES    (PAGE_BYTES)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_line_size       (in_line_size),
    .in_line_latency    (in_line_latency),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_page_bytes     (out_page_bytes),
    .out_lines_in_region(out_lines_in_region),
    .out_total_latency  (out_total_latency),
    .out_page_too_big   (out_page_too_big)
  );

  always #5 clk = ~clk;

  // Line words waiting for the driver, and page results the core owes us.
  line_word_tb_t      line_backlog[$];
  lcpts_pkg::result_t expected_pages[$];
  int                 mismatch_count = 0;

  // When set, neither side idles; used for the last stretch of the run.
  bit quiet = 1'b0;

  // Our own copy of the configuration registers, loaded with reset values.
  int tgt_bytes[lcpts_pkg::NUM_TARGETS] = '{0, 8, 16, 32};
  bit lat_on = 1'b1;

  // Running page state of the predictor.
  int line_idx = 0;
  int over_bytes[lcpts_pkg::NUM_TARGETS] = '{0, 0, 0, 0};
  int fit_lines[lcpts_pkg::NUM_TARGETS] = '{0, 0, 0, 0};
  int lat_total = 0;

  // Stimulus shaping state.
  int        stream_pos = 0;
  page_mix_t page_mix   = MIX_UNIFORM;
  int        flat_size  = 0;
  int        tie_left   = 0;
  bit        favor_tie  = 1'b0;

  int push_gap = 0;
  int pop_gap  = 0;
  bit push_go;
  line_word_tb_t      taken_line;
  lcpts_pkg::result_t want_page;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Folds one accepted line word into the page state. On the last line of a
  // page it picks the cheapest target, queues the page result and clears.
  task automatic tally_line(line_word_tb_t w);
    int sz;
    int cost;
    int best_cost;
    int best_fit;
    lcpts_pkg::result_t page;
    sz = (int'(w.size) > LINE_BYTES) ? LINE_BYTES : int'(w.size);
    for (int i = 0; i < lcpts_pkg::NUM_TARGETS; i++) begin
      if (sz > tgt_bytes[i]) begin
        over_bytes[i] += sz;
      end else begin
        fit_lines[i] += 1;
      end
    end
    lat_total += int'(w.latency);
    if (lat_total > int'(lcpts_pkg::LAT_MAX)) begin
      lat_total = int'(lcpts_pkg::LAT_MAX);
    end
    if (line_idx + 1 < LINES_PER_PAGE) begin
      line_idx++;
      return;
    end
    best_cost = 0;
    best_fit  = 0;
    for (int i = 0; i < lcpts_pkg::NUM_TARGETS; i++) begin
      cost = tgt_bytes[i] * LINES_PER_PAGE + META_BYTES_TB + over_bytes[i];
      // A later target wins a tie only when fewer lines fit it.
      if (i == 0 || cost < best_cost || (cost == best_cost && fit_lines[i] < best_fit)) begin
        best_cost = cost;
        best_fit  = fit_lines[i];
      end
    end
    if (best_cost > int'(lcpts_pkg::PAGE_MAX)) begin
      best_cost = int'(lcpts_pkg::PAGE_MAX);
    end
    if (best_fit > int'(lcpts_pkg::FIT_MAX)) begin
      best_fit = int'(lcpts_pkg::FIT_MAX);
    end
    page.page_bytes      = best_cost[lcpts_pkg::PAGE_W-1:0];
    page.lines_in_region = best_fit[lcpts_pkg::FIT_OUT_W-1:0];
    page.total_latency   = lat_on ? lat_total[lcpts_pkg::LAT_W-1:0] : '0;
    page.page_too_big    = (best_cost > PAGE_BYTES);
    expected_pages.push_back(page);
    line_idx  = 0;
    lat_total = 0;
    for (int i = 0; i < lcpts_pkg::NUM_TARGETS; i++) begin
      over_bytes[i] = 0;
      fit_lines[i]  = 0;
    end
  endtask

  task automatic queue_line(int sz, int lat);
    line_word_tb_t w;
    w.size    = sz[lcpts_pkg::SIZE_W-1:0];
    w.latency = lat[lcpts_pkg::LAT_IN_W-1:0];
    line_backlog.push_back(w);
    stream_pos++;
  endtask

  // Random line word. The content shape is chosen again at every page
  // boundary of the stream, which every queued word advances by one.
  task automatic queue_random_line();
    int pos;
    int sz;
    int lat;
    int pick;
    pos = stream_pos % LINES_PER_PAGE;
    if (pos == 0) begin
      pick = $urandom_range(0, 4);
      if (favor_tie && $urandom_range(0, 1) == 1) begin
        page_mix = MIX_TIE;
      end else begin
        case (pick)
          0: page_mix = MIX_UNIFORM;
          1: page_mix = MIX_FULL;
          2: page_mix = MIX_TIE;
          3: page_mix = MIX_SMALL;
          default: page_mix = MIX_FLAT;
        endcase
      end
      flat_size = $urandom_range(0, 127);
      tie_left  = LINES_PER_PAGE / 2;
    end
    case (page_mix)
      MIX_FULL: begin
        // Every line at or above the raw size, so no page fits the budget.
        sz = $urandom_range(LINE_BYTES, 127);
      end
      MIX_TIE: begin
        // Exactly half the page at 16 bytes and the rest at most 8: with
        // targets 16 and 8 both cost the same and the later one fits fewer.
        if ($urandom_range(1, LINES_PER_PAGE - pos) <= tie_left) begin
          sz = 16;
          tie_left--;
        end else begin
          sz = $urandom_range(0, 8);
        end
      end
      MIX_SMALL: begin
        sz = $urandom_range(0, 20);
      end
      MIX_FLAT: begin
        sz = flat_size;
      end
      default: begin
        sz = $urandom_range(0, 127);
      end
    endcase
    case ($urandom_range(0, 7))
      0: lat = 0;
      1: lat = 65535;
      default: lat = $urandom_range(0, 65535);
    endcase
    queue_line(sz, lat);
  endtask

  // One register write; our copy of the register is updated as the write is driven.
  task automatic write_reg(lcpts_pkg::cfg_index_t idx,
                           logic [lcpts_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == lcpts_pkg::CFG_LAT_EN) begin
      lat_on = value[0];
    end else begin
      tgt_bytes[int'(idx)] = int'(value);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_phase(int phase);
    int t[lcpts_pkg::NUM_TARGETS];
    bit en;
    favor_tie = 1'b0;
    case (phase)
      1: begin
        t = '{16, 8, 32, 64};
        en = 1'b0;
        favor_tie = 1'b1;
      end
      2: begin
        t = '{127, 127, 127, 127};
        en = 1'b1;
      end
      3: begin
        t = '{0, 0, 0, 0};
        en = 1'b0;
      end
      4: begin
        t = '{64, 0, 127, 64};
        en = 1'b1;
      end
      default: begin
        for (int i = 0; i < lcpts_pkg::NUM_TARGETS; i++) begin
          t[i] = $urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom_range(0, 127);
        end
        en = $urandom_range(0, 1);
      end
    endcase
    write_reg(lcpts_pkg::CFG_TARGET_0, t[0][lcpts_pkg::CFG_DATA_W-1:0]);
    write_reg(lcpts_pkg::CFG_TARGET_1, t[1][lcpts_pkg::CFG_DATA_W-1:0]);
    write_reg(lcpts_pkg::CFG_TARGET_2, t[2][lcpts_pkg::CFG_DATA_W-1:0]);
    write_reg(lcpts_pkg::CFG_TARGET_3, t[3][lcpts_pkg::CFG_DATA_W-1:0]);
    // Only bit 0 of the enable register counts; the upper bits are noise.
    write_reg(lcpts_pkg::CFG_LAT_EN, {6'($urandom_range(0, 63)), en});
  endtask

  // Waits until every queued word is taken and every page result has come
  // back. A partial page may still be in the core's pipeline, so the caller
  // adds a short settling pause before touching the registers.
  task automatic wait_idle();
    @(negedge clk);
    while (line_backlog.size() != 0 || in_push || expected_pages.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Input driver. A word is taken at an edge where push is high and full is
  // low; the predictor sees it at that same edge. The next word is then put
  // on the ports unless a random idle burst is running.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push  <= 1'b0;
      push_gap = 0;
    end else begin
      if (in_push && !in_full) begin
        taken_line = line_backlog.pop_front();
        tally_line(taken_line);
      end
      push_go = 1'b0;
      if (push_gap > 0) begin
        push_gap--;
      end else if (!quiet && line_backlog.size() != 0 && $urandom_range(0, 9) == 0) begin
        push_gap = $urandom_range(0, 16);
      end else begin
        push_go = (line_backlog.size() != 0);
      end
      in_push <= push_go;
      if (push_go) begin
        in_line_size    <= line_backlog[0].size;
        in_line_latency <= line_backlog[0].latency;
      end
    end
  end

  // Result monitor. Every popped word is checked field by field against the
  // oldest page result we predicted. Pop stalls in bursts like the driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_gap = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_pages.size() == 0) begin
          report_mismatch("unexpected page result, page_bytes", out_page_bytes, 0);
        end else begin
          want_page = expected_pages.pop_front();
          if (out_page_bytes !== want_page.page_bytes) begin
            report_mismatch("page_bytes", out_page_bytes, want_page.page_bytes);
          end
          if (out_lines_in_region !== want_page.lines_in_region) begin
            report_mismatch("lines_in_region", out_lines_in_region,
                            want_page.lines_in_region);
          end
          if (out_total_latency !== want_page.total_latency) begin
            report_mismatch("total_latency", out_total_latency, want_page.total_latency);
          end
          if (out_page_too_big !== want_page.page_too_big) begin
            report_mismatch("page_too_big", out_page_too_big, want_page.page_too_big);
          end
        end
      end
      if (pop_gap > 0) begin
        pop_gap--;
        out_pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        pop_gap = $urandom_range(0, 16);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Main sequence: reset once, then phases of random pages. Between phases
  // the core is drained and all registers get new values. Phase lengths
  // need not be multiples of a page, so a register change often lands
  // mid-page and the page mixes old and new targets.
  initial begin
    int n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        program_phase(phase);
      end
      @(negedge clk);
      if (phase == PHASES - 1) begin
        quiet = 1'b1;
      end
      if (phase == 0) begin
        // Field extremes, oversized lines that clamp to the raw line size,
        // and latency corner values; they open the first page.
        queue_line(0, 0);
        queue_line(64, 65535);
        queue_line(65, 1);
        queue_line(127, 32768);
        queue_line(1, 21845);
        queue_line(63, 43690);
        queue_line(32, 255);
        queue_line(33, 65280);
        queue_line(8, 4660);
        queue_line(9, 0);
        queue_line(16, 65535);
        queue_line(17, 12345);
        queue_line(31, 54321);
        queue_line(96, 7);
        queue_line(85, 65534);
        queue_line(42, 1024);
        queue_line(0, 65535);
        queue_line(127, 0);
        queue_line(2, 16384);
        queue_line(4, 8192);
      end
      n = $urandom_range(170, 230);
      repeat (n) queue_random_line();
    end
    wait_idle();
    // Any stray result still in the pipeline would show up here.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop: far beyond the slowest correct run, in which every word and
  // every result waits out the longest idle burst.
  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
